FILE: rtl/fmwl_pkg.sv
// Package for the FM operator waveform lookup: waveform codes, widths,
// the quarter-wave log-sine ROM and the exp ROM builder. No dependencies.
package fmwl_pkg;

  localparam int PHASE_W  = 10;
  localparam int WAVE_W   = 2;
  localparam int LOG_W    = 16;
  localparam int SAMPLE_W = 11;
  localparam int ROM_W    = 12;
  localparam int SHIFT_W  = 7;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE      = 2'd0,
    WAVE_HALF_SINE = 2'd1,
    WAVE_RECT_SINE = 2'd2,
    WAVE_PSEUDO_SAW = 2'd3
  } wave_t;

  localparam logic [LOG_W-1:0] SIGN_BIT = 16'h8000;
  localparam logic [LOG_W-1:0] NEG_ZERO = 16'h8fff;
  localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = 7'd13;

  typedef logic [ROM_W-1:0] rom_t [256];

  localparam rom_t LOGSIN_ROM = '{
    12'h859,12'h6c3,12'h607,12'h58b,12'h52e,12'h4e4,12'h4a6,12'h471,
    12'h443,12'h41a,12'h3f5,12'h3d3,12'h3b5,12'h398,12'h37e,12'h365,
    12'h34e,12'h339,12'h324,12'h311,12'h2ff,12'h2ed,12'h2dc,12'h2cd,
    12'h2bd,12'h2af,12'h2a0,12'h293,12'h286,12'h279,12'h26d,12'h261,
    12'h256,12'h24b,12'h240,12'h236,12'h22c,12'h222,12'h218,12'h20f,
    12'h206,12'h1fd,12'h1f5,12'h1ec,12'h1e4,12'h1dc,12'h1d4,12'h1cd,
    12'h1c5,12'h1be,12'h1b7,12'h1b0,12'h1a9,12'h1a2,12'h19b,12'h195,
    12'h18f,12'h188,12'h182,12'h17c,12'h177,12'h171,12'h16b,12'h166,
    12'h160,12'h15b,12'h155,12'h150,12'h14b,12'h146,12'h141,12'h13c,
    12'h137,12'h133,12'h12e,12'h129,12'h125,12'h121,12'h11c,12'h118,
    12'h114,12'h10f,12'h10b,12'h107,12'h103,12'h0ff,12'h0fb,12'h0f8,
    12'h0f4,12'h0f0,12'h0ec,12'h0e9,12'h0e5,12'h0e2,12'h0de,12'h0db,
    12'h0d7,12'h0d4,12'h0d1,12'h0cd,12'h0ca,12'h0c7,12'h0c4,12'h0c1,
    12'h0be,12'h0bb,12'h0b8,12'h0b5,12'h0b2,12'h0af,12'h0ac,12'h0a9,
    12'h0a7,12'h0a4,12'h0a1,12'h09f,12'h09c,12'h099,12'h097,12'h094,
    12'h092,12'h08f,12'h08d,12'h08a,12'h088,12'h086,12'h083,12'h081,
    12'h07f,12'h07d,12'h07a,12'h078,12'h076,12'h074,12'h072,12'h070,
    12'h06e,12'h06c,12'h06a,12'h068,12'h066,12'h064,12'h062,12'h060,
    12'h05e,12'h05c,12'h05b,12'h059,12'h057,12'h055,12'h053,12'h052,
    12'h050,12'h04e,12'h04d,12'h04b,12'h04a,12'h048,12'h046,12'h045,
    12'h043,12'h042,12'h040,12'h03f,12'h03e,12'h03c,12'h03b,12'h039,
    12'h038,12'h037,12'h035,12'h034,12'h033,12'h031,12'h030,12'h02f,
    12'h02e,12'h02d,12'h02b,12'h02a,12'h029,12'h028,12'h027,12'h026,
    12'h025,12'h024,12'h023,12'h022,12'h021,12'h020,12'h01f,12'h01e,
    12'h01d,12'h01c,12'h01b,12'h01a,12'h019,12'h018,12'h017,12'h017,
    12'h016,12'h015,12'h014,12'h014,12'h013,12'h012,12'h011,12'h011,
    12'h010,12'h00f,12'h00f,12'h00e,12'h00d,12'h00d,12'h00c,12'h00c,
    12'h00b,12'h00a,12'h00a,12'h009,12'h009,12'h008,12'h008,12'h007,
    12'h007,12'h007,12'h006,12'h006,12'h005,12'h005,12'h005,12'h004,
    12'h004,12'h004,12'h003,12'h003,12'h003,12'h002,12'h002,12'h002,
    12'h002,12'h001,12'h001,12'h001,12'h001,12'h001,12'h001,12'h001,
    12'h000,12'h000,12'h000,12'h000,12'h000,12'h000,12'h000,12'h000
  };

  // Entry j holds 2*round(1024*2^((255-j)/256)), evaluated at elaboration.
  function automatic rom_t build_exp_rom();
    rom_t rom;
    real  x;
    for (int j = 0; j < 256; j++) begin
      x = 1024.0 * (2.0 ** ((255.0 - real'(j)) / 256.0));
      rom[j] = ROM_W'(2 * $rtoi(x + 0.5));
    end
    return rom;
  endfunction

  localparam rom_t EXP_ROM = build_exp_rom();

endpackage

FILE: rtl/fm_operator_waveform_lookup_top.sv
// FM operator waveform lookup: phase and waveform in, log value and linear
// sample out. Uses fmwl_pkg for the ROMs, codes and widths.
//
// Usage: present phase and waveform on the in_ channel with in_valid; the
// item is taken when in_valid and in_ready are both high. Each item gives
// exactly one result on the out_ channel (log_value and sample), taken when
// out_valid and out_ready are both high. Results leave in input order.
// An accepted item passes the stage 1 and stage 2 registers into the output
// register, which drives out_valid. Throughput is one item per cycle while the
// receiver does not stall: three register stages (log-sine ROM, exp ROM, shift and
// sign) each hold one item, and every stage moves whenever the one after
// it is empty or moving.
// When the receiver stalls, the output register holds its result and the
// stages behind it fill; in_ready drops only once all three are full, so
// nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties all stages; no result is pending
// afterwards. The ROMs are constant logic and need no setup time.
module fm_operator_waveform_lookup_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fmwl_pkg::PHASE_W-1:0]      in_phase,
  input  logic [fmwl_pkg::WAVE_W-1:0]       in_waveform,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fmwl_pkg::LOG_W-1:0]        out_log_value,
  output logic signed [fmwl_pkg::SAMPLE_W-1:0] out_sample
);

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  assign en3 = !v3_r || out_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  // Stage 1: log-sine lookup with mirroring and waveform shaping.
  logic [fmwl_pkg::LOG_W-1:0] lv1_nxt, lv1_r;
  logic [7:0] q_idx;
  logic [fmwl_pkg::LOG_W-1:0] full_lv, rect_lv, plain_lv;

  always_comb begin
    q_idx    = in_phase[8] ? ~in_phase[7:0] : in_phase[7:0];
    plain_lv = {4'd0, fmwl_pkg::LOGSIN_ROM[in_phase[7:0]]};
    rect_lv  = {4'd0, fmwl_pkg::LOGSIN_ROM[q_idx]};
    full_lv  = in_phase[9] ? (rect_lv | fmwl_pkg::SIGN_BIT) : rect_lv;
    case (fmwl_pkg::wave_t'(in_waveform))
      fmwl_pkg::WAVE_SINE:       lv1_nxt = full_lv;
      fmwl_pkg::WAVE_HALF_SINE:  lv1_nxt = in_phase[9] ? fmwl_pkg::NEG_ZERO : full_lv;
      fmwl_pkg::WAVE_RECT_SINE:  lv1_nxt = rect_lv;
      fmwl_pkg::WAVE_PSEUDO_SAW: lv1_nxt = in_phase[8] ? fmwl_pkg::NEG_ZERO : plain_lv;
      default:                   lv1_nxt = full_lv;
    endcase
  end

  // Stage 2: exp lookup on the mantissa byte.
  logic [fmwl_pkg::LOG_W-1:0] lv2_r;
  logic [fmwl_pkg::ROM_W-1:0] t2_nxt, t2_r;
  assign t2_nxt = fmwl_pkg::EXP_ROM[lv1_r[7:0]];

  // Stage 3: shift by the exponent, drop two bits, invert for negative.
  logic [fmwl_pkg::SHIFT_W-1:0]  sh;
  logic [fmwl_pkg::ROM_W-1:0]    shifted;
  logic [fmwl_pkg::SAMPLE_W-1:0] mag, s3_nxt;
  logic [fmwl_pkg::LOG_W-1:0]    out_log_value_r;
  logic [fmwl_pkg::SAMPLE_W-1:0] out_sample_r;

  always_comb begin
    sh      = lv2_r[14:8];
    shifted = (sh >= fmwl_pkg::SHIFT_LIMIT) ? '0 : (t2_r >> sh);
    mag     = {1'b0, shifted[11:2]};
    s3_nxt  = lv2_r[15] ? ~mag : mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) lv1_r <= lv1_nxt;
    if (en2) begin
      lv2_r <= lv1_r;
      t2_r  <= t2_nxt;
    end
    if (en3) begin
      out_log_value_r <= lv2_r;
      out_sample_r    <= s3_nxt;
    end
  end

  assign out_valid     = v3_r;
  assign out_log_value = out_log_value_r;
  assign out_sample    = out_sample_r;

  // Negative zero always decodes to a sample of minus one.
  a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_log_value == fmwl_pkg::NEG_ZERO) |-> (out_sample == -11'sd1))
    else $error("negative zero did not give -1");

  // The sample sign follows the log sign bit.
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample[10] == out_log_value[15]))
    else $error("sample sign differs from log sign");

  // An accepted item always lands in the first stage.
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted item lost in stage one");

  // A full pipeline with a stalled output must refuse input.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline full");

endmodule

FILE: test/fm_operator_waveform_lookup_checker.sv
// Checker for the FM operator waveform lookup: watches both channels, predicts
// each sample and compares it with the block's output. Depends on fmwl_pkg.
module fm_operator_waveform_lookup_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [fmwl_pkg::PHASE_W-1:0]         in_phase,
  input  logic [fmwl_pkg::WAVE_W-1:0]          in_waveform,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [fmwl_pkg::LOG_W-1:0]           out_log_value,
  input  logic signed [fmwl_pkg::SAMPLE_W-1:0] out_sample,
  output int                                   fail_count,
  output int                                   pending
);

  typedef struct packed {
    logic [fmwl_pkg::LOG_W-1:0]           log_value;
    logic signed [fmwl_pkg::SAMPLE_W-1:0] sample;
  } sample_t;

  sample_t       expected_samples[$];
  logic [11:0]   exp_table[256];

  initial begin
    real x;
    for (int j = 0; j < 256; j++) begin
      x = 1024.0 * (2.0 ** ((255.0 - real'(j)) / 256.0));
      exp_table[j] = 12'(2 * $rtoi(x + 0.5));
    end
  end

  function automatic logic [fmwl_pkg::LOG_W-1:0] quarter_sine(
      logic [fmwl_pkg::PHASE_W-1:0] p);
    logic [fmwl_pkg::LOG_W-1:0] v;
    v = p[8] ? fmwl_pkg::LOG_W'(fmwl_pkg::LOGSIN_ROM[~p[7:0]])
             : fmwl_pkg::LOG_W'(fmwl_pkg::LOGSIN_ROM[p[7:0]]);
    if (p[9]) v |= fmwl_pkg::SIGN_BIT;
    return v;
  endfunction

  function automatic sample_t operator_sample(logic [fmwl_pkg::PHASE_W-1:0] p,
                                              fmwl_pkg::wave_t wf);
    sample_t     r;
    logic [6:0]  sh;
    logic [11:0] mag;
    case (wf)
      fmwl_pkg::WAVE_SINE:      r.log_value = quarter_sine(p);
      fmwl_pkg::WAVE_HALF_SINE: r.log_value = p[9] ? fmwl_pkg::NEG_ZERO : quarter_sine(p);
      fmwl_pkg::WAVE_RECT_SINE: r.log_value = quarter_sine({1'b0, p[8:0]});
      default: r.log_value = p[8] ? fmwl_pkg::NEG_ZERO
                                  : fmwl_pkg::LOG_W'(fmwl_pkg::LOGSIN_ROM[p[7:0]]);
    endcase
    sh  = r.log_value[14:8];
    mag = (sh >= 13) ? 12'd0 : ((exp_table[r.log_value[7:0]] >> sh) >> 2);
    if (r.log_value[15]) mag = ~mag;
    r.sample = mag[fmwl_pkg::SAMPLE_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    sample_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_samples.push_back(operator_sample(in_phase,
                                                   fmwl_pkg::wave_t'(in_waveform)));
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected sample: log_value %h sample %0d", out_log_value, out_sample);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if (out_log_value !== want.log_value) begin
            $error("log_value: expected %h, actual %h", want.log_value, out_log_value);
            fail_count++;
          end
          if (out_sample !== want.sample) begin
            $error("sample: expected %0d, actual %0d", want.sample, out_sample);
            fail_count++;
          end
        end
      end
    end
    pending = expected_samples.size();
  end

endmodule

FILE: test/tb_fm_operator_waveform_lookup_top.sv
// Testbench top for the FM operator waveform lookup: drives directed and random
// phase/waveform items under varying idle patterns. Depends on fmwl_pkg and the checker.
module tb_fm_operator_waveform_lookup_top;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic [fmwl_pkg::PHASE_W-1:0]         in_phase = '0;
  logic [fmwl_pkg::WAVE_W-1:0]          in_waveform = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic [fmwl_pkg::LOG_W-1:0]           out_log_value;
  logic signed [fmwl_pkg::SAMPLE_W-1:0] out_sample;
  int                                   fail_count;
  int                                   pending;
  int                                   send_idle_pct = 0;
  int                                   stall_pct = 0;

  always #5 clk = ~clk;

  fm_operator_waveform_lookup_top u_dut (.*);

  fm_operator_waveform_lookup_checker u_checker (.*);

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // Drives one item; valid stays high back to back unless an idle cycle is rolled.
  task automatic send_item(logic [fmwl_pkg::PHASE_W-1:0] p,
                           logic [fmwl_pkg::WAVE_W-1:0] wf);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_phase <= fmwl_pkg::PHASE_W'($urandom);
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_phase    <= p;
    in_waveform <= wf;
    do @(posedge clk); while (!in_ready);
  endtask

  // The first edge lets the checker record the last accepted item.
  task automatic drain_samples();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [fmwl_pkg::PHASE_W-1:0] corner_phases[6] = '{10'd0, 10'd255, 10'd256, 10'd511,
                                                       10'd512, 10'd1023};
    logic [fmwl_pkg::PHASE_W-1:0] p;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_phases[i])
      for (int w = 0; w < 4; w++) send_item(corner_phases[i], fmwl_pkg::WAVE_W'(w));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      for (int n = 0; n < 430; n++) begin
        // Bursts with no idling at all keep every stage full for a while.
        if (n % 100 == 50) begin send_idle_pct = 0; stall_pct = 0; end
        if (n % 100 == 80 && ph != 0) begin
          send_idle_pct = (ph == 2) ? 0 : (ph == 1 ? 53 : 23);
          stall_pct     = (ph == 1) ? 0 : (ph == 2 ? 53 : 23);
        end
        p = fmwl_pkg::PHASE_W'($urandom);
        send_item(p, fmwl_pkg::WAVE_W'($urandom));
      end
      if (ph == 1) drain_samples();
    end

    drain_samples();
    stall_pct = 0;
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
